/* hw/rtl/pfss_pkg.sv */
package pfss_pkg;

    localparam int QUERY_W        = 16;
    localparam int SUM_W          = 16;
    localparam int QUERY_SPAN     = 65536;
    localparam int TABLE_SIZE_DEF = 65536;

    typedef enum logic [2:0] {
        SV_CLEAR,
        SV_PRIME_START,
        SV_PRIME_TEST,
        SV_MARK,
        SV_DONE
    } sieve_state_t;

    typedef enum logic {
        QY_IDLE,
        QY_WALK
    } query_state_t;

    // entries at or above the query span are never looked up
    function automatic int table_depth(input int size);
        int depth;
        depth = (size > QUERY_SPAN) ? QUERY_SPAN : size;
        return depth;
    endfunction

endpackage

/* hw/rtl/pfss_query_if.sv */
interface pfss_query_if import pfss_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [QUERY_W-1:0] query_value;

    modport source (output valid, output query_value, input ready);
    modport sink (input valid, input query_value, output ready);

endinterface

/* hw/rtl/pfss_result_if.sv */
interface pfss_result_if import pfss_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] factor_sum;

    modport source (output valid, output factor_sum, input ready);
    modport sink (input valid, input factor_sum, output ready);

endinterface

/* hw/rtl/pfss_ram.sv */
module pfss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/pfss_sieve.sv */
module pfss_sieve import pfss_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int DEPTH     = table_depth(TABLE_SIZE),
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int SPF_W     = (ADDR_W + 1) / 2,
    localparam int COF_W     = ADDR_W - 1,
    localparam int ENTRY_W   = SPF_W + COF_W
) (
    input  logic               clk,
    input  logic               rst_n,
    output logic               done,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [ENTRY_W-1:0] rd_data,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [ENTRY_W-1:0] wr_data
);

    sieve_state_t       state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [SPF_W:0]     p_reg, p_next;
    logic [ADDR_W:0]    sq_reg, sq_next;
    logic [ADDR_W:0]    m_reg, m_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [COF_W-1:0]   pend_cof_reg, pend_cof_next;

    logic [SPF_W-1:0]   rd_spf;
    logic               sq_done;
    logic               issue;
    logic               last_clear;
    logic               mark_end;

    assign rd_spf     = rd_data[ENTRY_W-1 -: SPF_W];
    assign sq_done    = sq_reg >= (ADDR_W + 1)'(DEPTH);
    assign issue      = m_reg < (ADDR_W + 1)'(DEPTH);
    assign last_clear = clr_reg == ADDR_W'(DEPTH - 1);
    assign mark_end   = !issue && !pend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SV_CLEAR:
            begin
                if (last_clear)
                begin
                    state_next = SV_PRIME_START;
                end
            end
            SV_PRIME_START:
            begin
                state_next = sq_done ? SV_DONE : SV_PRIME_TEST;
            end
            SV_PRIME_TEST:
            begin
                state_next = (rd_spf == '0) ? SV_MARK : SV_PRIME_START;
            end
            SV_MARK:
            begin
                if (mark_end)
                begin
                    state_next = SV_PRIME_START;
                end
            end
            SV_DONE:
            begin
                state_next = SV_DONE;
            end
            default:
            begin
                state_next = SV_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        done    = 1'b0;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(p_reg);
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = {SPF_W'(p_reg), pend_cof_reg};
        unique case (state_reg)
            SV_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            SV_PRIME_START:
            begin
                rd_en = !sq_done;
            end
            SV_PRIME_TEST:
            begin
                rd_en = 1'b0;
            end
            SV_MARK:
            begin
                rd_en   = issue;
                rd_addr = m_reg[ADDR_W-1:0];
                wr_en   = pend_reg && (rd_spf == '0);
            end
            SV_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_next       = clr_reg;
        p_next         = p_reg;
        sq_next        = sq_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_cof_next  = pend_cof_reg;
        unique case (state_reg)
            SV_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
            SV_PRIME_TEST:
            begin
                if (rd_spf == '0)
                begin
                    m_next = sq_reg;
                    k_next = ADDR_W'(p_reg);
                end
                else
                begin
                    p_next  = p_reg + (SPF_W + 1)'(1);
                    sq_next = sq_reg + (ADDR_W + 1)'({p_reg, 1'b1});
                end
            end
            SV_MARK:
            begin
                pend_next      = issue;
                pend_addr_next = m_reg[ADDR_W-1:0];
                pend_cof_next  = k_reg[COF_W-1:0];
                if (issue)
                begin
                    m_next = m_reg + (ADDR_W + 1)'(p_reg);
                    k_next = k_reg + ADDR_W'(1);
                end
                if (mark_end)
                begin
                    p_next  = p_reg + (SPF_W + 1)'(1);
                    sq_next = sq_reg + (ADDR_W + 1)'({p_reg, 1'b1});
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SV_CLEAR;
            clr_reg   <= '0;
            p_reg     <= (SPF_W + 1)'(2);
            sq_reg    <= (ADDR_W + 1)'(4);
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            p_reg     <= p_next;
            sq_reg    <= sq_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        k_reg         <= k_next;
        pend_addr_reg <= pend_addr_next;
        pend_cof_reg  <= pend_cof_next;
    end

endmodule

/* hw/rtl/pfss_query.sv */
module pfss_query import pfss_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int DEPTH     = table_depth(TABLE_SIZE),
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int SPF_W     = (ADDR_W + 1) / 2,
    localparam int COF_W     = ADDR_W - 1,
    localparam int ENTRY_W   = SPF_W + COF_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               table_ready,
    pfss_query_if.sink         query,
    pfss_result_if.source      result,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [ENTRY_W-1:0] rd_data
);

    query_state_t       state_reg, state_next;
    logic [ADDR_W-1:0]  rest_reg, rest_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               beyond_reg, beyond_next;
    logic               out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;

    logic               accept;
    logic               beyond;
    logic [SPF_W-1:0]   step_spf;
    logic [COF_W-1:0]   step_cof;
    logic               slot_free;
    logic               load;
    logic [SUM_W-1:0]   final_sum;

    assign accept    = query.valid && query.ready;
    assign beyond    = int'(query.query_value) >= DEPTH;
    assign step_spf  = beyond_reg ? '0 : rd_data[ENTRY_W-1 -: SPF_W];
    assign step_cof  = rd_data[COF_W-1:0];
    assign slot_free = !out_valid_reg || result.ready;
    assign final_sum = sum_reg + ((rest_reg > ADDR_W'(1)) ? SUM_W'(rest_reg) : '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            QY_IDLE:
            begin
                if (accept)
                begin
                    state_next = QY_WALK;
                end
            end
            QY_WALK:
            begin
                if ((step_spf == '0) && slot_free)
                begin
                    state_next = QY_IDLE;
                end
            end
            default:
            begin
                state_next = QY_IDLE;
            end
        endcase
    end

    always_comb
    begin
        query.ready = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = query.query_value[ADDR_W-1:0];
        load        = 1'b0;
        unique case (state_reg)
            QY_IDLE:
            begin
                query.ready = table_ready;
                rd_en       = accept && !beyond;
            end
            QY_WALK:
            begin
                rd_en   = step_spf != '0;
                rd_addr = ADDR_W'(step_cof);
                load    = (step_spf == '0) && slot_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rest_next   = rest_reg;
        sum_next    = sum_reg;
        beyond_next = beyond_reg;
        if (state_reg == QY_IDLE)
        begin
            if (accept)
            begin
                rest_next   = beyond ? '0 : query.query_value[ADDR_W-1:0];
                sum_next    = '0;
                beyond_next = beyond;
            end
        end
        else if (step_spf != '0)
        begin
            sum_next  = sum_reg + SUM_W'(step_spf);
            rest_next = ADDR_W'(step_cof);
        end
        out_valid_next = load || (out_valid_reg && !result.ready);
        out_sum_next   = load ? final_sum : out_sum_reg;
    end

    assign result.valid      = out_valid_reg;
    assign result.factor_sum = out_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= QY_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        sum_reg     <= sum_next;
        beyond_reg  <= beyond_next;
        out_sum_reg <= out_sum_next;
    end

endmodule

/* hw/rtl/prime_factor_sum_sieve_core.sv */
// Channel  Dir  Word                Handshake
// query    in   query_value[15:0]   valid / ready
// result   out  factor_sum[15:0]    valid / ready
//
// A query walks its prime factors with multiplicity: one read of the table RAM per
// factor, chained through its single read port.
// After reset the table RAM is cleared one entry per cycle, all min(TABLE_SIZE, 65536)
// entries, then the sieve marks one multiple per cycle; query.ready stays low until the
// sieve is done.
// A stalled result holds in the output register; the next query is still taken and
// its walk waits on its last step until the register frees up.
module prime_factor_sum_sieve_core import pfss_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int DEPTH     = table_depth(TABLE_SIZE),
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int SPF_W     = (ADDR_W + 1) / 2,
    localparam int COF_W     = ADDR_W - 1,
    localparam int ENTRY_W   = SPF_W + COF_W
) (
    input  logic          clk,
    input  logic          rst_n,
    pfss_query_if.sink    query,
    pfss_result_if.source result
);

    logic               sieve_done;
    logic               sieve_rd_en;
    logic [ADDR_W-1:0]  sieve_rd_addr;
    logic               qry_rd_en;
    logic [ADDR_W-1:0]  qry_rd_addr;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    pfss_sieve #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_sieve (
        .clk     (clk),
        .rst_n   (rst_n),
        .done    (sieve_done),
        .rd_en   (sieve_rd_en),
        .rd_addr (sieve_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    pfss_query #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_query (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_ready (sieve_done),
        .query       (query),
        .result      (result),
        .rd_en       (qry_rd_en),
        .rd_addr     (qry_rd_addr),
        .rd_data     (ram_rd_data)
    );

    assign ram_rd_en   = sieve_done ? qry_rd_en : sieve_rd_en;
    assign ram_rd_addr = sieve_done ? qry_rd_addr : sieve_rd_addr;

    pfss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    a_ready_after_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        query.ready |-> sieve_done)
        else $error("query taken before the table is built");

    a_table_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        sieve_done |-> !ram_wr_en)
        else $error("table written after the sieve finished");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        sieve_done |=> sieve_done)
        else $error("sieve done dropped");

    a_single_reader: assert property (@(posedge clk) disable iff (!rst_n)
        !(sieve_rd_en && qry_rd_en))
        else $error("sieve and query read the table together");
`endif

endmodule
